// ===== hdl/dvrt_pkg.sv =====
package dvrt_pkg;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_ADVERT = 2'd2,
    OP_TICK   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_ENTRY  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_IMPROVED  = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_LEN   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WRITE,
    S_EMIT,
    S_BCAST
  } state_e;

  localparam logic [23:0] IntervalReset = 24'd1000000;
  localparam logic [23:0] TickMax       = 24'hFFFFFF;
  localparam int unsigned MaxPrefixLen  = 32;
  // Nominal port count; ports are stored and emitted as given
  localparam int unsigned PortCount     = 16;

  // Classified command passed from the front end to the back end
  typedef struct packed {
    opcode_e     op;
    logic [31:0] address;
    logic [31:0] route_mask;
    logic        bad_len;
    logic [15:0] distance;
    logic [3:0]  port;
  } cmd_t;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic        hit;
    logic [3:0]  out_port;
    status_e     status;
    logic [31:0] adv_prefix;
    logic [31:0] adv_mask;
    logic [15:0] adv_distance;
    logic        last;
  } result_t;

endpackage

// ===== hdl/dvrt_front.sv =====
module dvrt_front
  import dvrt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] address_i,
  input  logic [31:0] route_mask_i,
  input  logic [5:0]  prefix_length_i,
  input  logic [15:0] hop_distance_i,
  input  logic [3:0]  port_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  cmd_t q0_q, q1_q;
  logic [1:0] cnt_q, cnt_d;
  cmd_t cls;
  logic [31:0] m;
  logic push, pop;

  // Classify: build static mask, saturate advertised distance
  always_comb begin
    m = '0;
    if (prefix_length_i != 6'd0 && prefix_length_i <= 6'(MaxPrefixLen))
      m = 32'hFFFFFFFF << (6'd32 - prefix_length_i);
    cls.op = opcode_e'(opcode_i);
    cls.port = port_i;
    cls.bad_len = prefix_length_i > 6'(MaxPrefixLen);
    if (opcode_e'(opcode_i) == OP_ADD) begin
      cls.address = address_i & m;
      cls.route_mask = m;
      cls.distance = hop_distance_i;
    end else begin
      cls.address = address_i;
      cls.route_mask = route_mask_i;
      cls.distance = (hop_distance_i == 16'hFFFF) ? 16'hFFFF : hop_distance_i + 16'd1;
    end
  end

  assign in_ready_o  = cnt_q != 2'd2;
  assign cmd_valid_o = cnt_q != 2'd0;
  assign cmd_o       = q0_q;
  assign push = in_valid_i && in_ready_o;
  assign pop  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  // Two-entry queue; head in q0
  always_ff @(posedge clk_i) begin
    if (pop) begin
      q0_q <= (cnt_q == 2'd2) ? q1_q : cls;
      if (push && cnt_q == 2'd2) q1_q <= cls;
    end else if (push) begin
      if (cnt_q == 2'd0) q0_q <= cls;
      else q1_q <= cls;
    end
  end

`ifndef ASSERT_OFF
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !in_ready_o) else $error("push into full queue");
  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> cnt_q == $past(cnt_q) - 2'd1) else $error("bad pop count");
`endif

endmodule

// ===== hdl/dvrt_back.sv =====
module dvrt_back
  import dvrt_pkg::*;
#(
  parameter int unsigned ROUTE_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [23:0] interval_i,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  cmd_t        cmd_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output result_t     res_o
);

  localparam int unsigned IdxW = (ROUTE_SLOTS > 1) ? $clog2(ROUTE_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(ROUTE_SLOTS + 1);

  // Table memory, one read port and one write port
  logic [83:0] mem [ROUTE_SLOTS];
  logic [83:0] rd_q;

  state_e state_q, state_d;
  cmd_t cmd_q;
  logic [CntW-1:0] count_q, count_d, idx_q, idx_d;
  logic [23:0] ticks_q, ticks_d;
  logic found_q, found_d;
  logic [31:0] bmask_q, bmask_d;
  logic [15:0] bdist_q, bdist_d;
  logic [3:0] bport_q, bport_d;
  logic [IdxW-1:0] widx_q, widx_d;
  logic wr_en;
  logic [83:0] wr_data;
  logic [IdxW-1:0] rd_addr;
  logic rd_valid_q, rd_valid_d;
  result_t res_q, res_d;
  logic res_valid_q, res_valid_d;
  logic [31:0] e_pfx, e_msk;
  logic [15:0] e_dst;
  logic [3:0] e_prt;
  logic [23:0] tnext;
  logic rd_last;

  assign {e_pfx, e_msk, e_dst, e_prt} = rd_q;
  assign res_o = res_q;
  assign res_valid_o = res_valid_q;
  assign tnext = (ticks_q == TickMax) ? ticks_q : ticks_q + 24'd1;
  assign rd_last = idx_q == count_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[widx_q] <= wr_data;
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ticks_q <= '0;
      res_valid_q <= 1'b0;
      rd_valid_q <= 1'b0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ticks_q <= ticks_d;
      res_valid_q <= res_valid_d;
      rd_valid_q <= rd_valid_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    found_q <= found_d;
    bmask_q <= bmask_d;
    bdist_q <= bdist_d;
    bport_q <= bport_d;
    widx_q <= widx_d;
    res_q <= res_d;
  end

  // Sequencer: scan table one entry a cycle through the read port; a broadcast holds while the output is busy
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ticks_d = ticks_q;
    idx_d = idx_q;
    found_d = found_q;
    bmask_d = bmask_q;
    bdist_d = bdist_q;
    bport_d = bport_q;
    widx_d = widx_q;
    wr_en = 1'b0;
    wr_data = {cmd_q.address, cmd_q.route_mask, cmd_q.distance, cmd_q.port};
    rd_addr = idx_q[IdxW-1:0];
    rd_valid_d = 1'b0;
    res_d = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        // Take a new command only once the result register is free
        cmd_ready_o = !res_valid_q || res_ready_i;
        if (cmd_valid_i && cmd_ready_o) begin
          found_d = 1'b0;
          idx_d = '0;
          rd_addr = '0;
          res_d = '0;
          unique case (cmd_i.op)
            OP_ADD: begin
              res_d.kind = KIND_STATUS;
              if (cmd_i.bad_len) begin
                res_d.status = ST_BAD_LEN;
                res_d.last = 1'b1;
                state_d = S_EMIT;
              end else if (count_q == CntW'(ROUTE_SLOTS)) begin
                res_d.status = ST_FULL;
                res_d.last = 1'b1;
                state_d = S_EMIT;
              end else begin
                res_d.status = ST_ADDED;
                widx_d = count_q[IdxW-1:0];
                state_d = S_WRITE;
              end
            end
            OP_TICK: begin
              if (tnext >= interval_i) begin
                ticks_d = '0;
                if (count_q != '0) begin
                  rd_valid_d = 1'b1;
                  idx_d = CntW'(1);
                  state_d = S_BCAST;
                end
              end else begin
                ticks_d = tnext;
              end
            end
            default: begin
              if (count_q != '0) begin
                rd_valid_d = 1'b1;
                idx_d = CntW'(1);
              end
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_valid_q) begin
          if (cmd_q.op == OP_LOOKUP) begin
            if ((cmd_q.address & e_msk) == e_pfx &&
                (!found_q || e_msk > bmask_q ||
                 (e_msk == bmask_q && e_dst < bdist_q))) begin
              found_d = 1'b1;
              bmask_d = e_msk;
              bdist_d = e_dst;
              bport_d = e_prt;
            end
          end else if (!found_q && e_pfx == cmd_q.address &&
                       e_msk == cmd_q.route_mask) begin
            found_d = 1'b1;
            bdist_d = e_dst;
            widx_d = IdxW'(idx_q - CntW'(1));
          end
        end
        if (!rd_last) begin
          rd_valid_d = 1'b1;
          idx_d = idx_q + CntW'(1);
        end
        if (rd_last && !rd_valid_d && !res_valid_q) begin
          res_d = '0;
          res_d.last = 1'b1;
          if (cmd_q.op == OP_LOOKUP) begin
            res_d.kind = KIND_LOOKUP;
            res_d.hit = found_d;
            res_d.out_port = found_d ? bport_d : 4'd0;
            res_valid_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            res_d.kind = KIND_STATUS;
            if (found_d) begin
              if (cmd_q.distance < bdist_d) begin
                res_d.status = ST_IMPROVED;
                wr_data = {cmd_q.address, cmd_q.route_mask, cmd_q.distance, cmd_q.port};
                wr_en = 1'b0;
                state_d = S_WRITE;
              end else begin
                res_d.status = ST_UNCHANGED;
                res_valid_d = 1'b1;
                state_d = S_IDLE;
              end
            end else if (count_q == CntW'(ROUTE_SLOTS)) begin
              res_d.status = ST_FULL;
              res_valid_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              res_d.status = ST_ADDED;
              widx_d = count_q[IdxW-1:0];
              state_d = S_WRITE;
            end
          end
        end else if (rd_last && !rd_valid_d) begin
          // result slot busy: hold last entry evaluated, retry next cycle
          idx_d = idx_q;
        end
      end
      S_WRITE: begin
        if (!res_valid_q) begin
          wr_en = 1'b1;
          if (res_q.status == ST_ADDED) count_d = count_q + CntW'(1);
          if (cmd_q.op == OP_ADVERT) ticks_d = '0;
          res_d.last = 1'b1;
          res_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!res_valid_q) begin
          res_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_BCAST: begin
        // rd_q holds entry idx_q-1; hold the read while the output is busy
        rd_addr = IdxW'(idx_q - CntW'(1));
        if (!res_valid_q || res_ready_i) begin
          res_d = '0;
          res_d.kind = KIND_ENTRY;
          res_d.out_port = e_prt;
          res_d.adv_prefix = e_pfx;
          res_d.adv_mask = e_msk;
          res_d.adv_distance = e_dst;
          res_d.last = rd_last;
          res_valid_d = 1'b1;
          rd_addr = idx_q[IdxW-1:0];
          if (rd_last) state_d = S_IDLE;
          else idx_d = idx_q + CntW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(ROUTE_SLOTS)) else $error("entry count overflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == $past(count_q) + CntW'(1))
    else $error("entry count jumped");
  a_hold_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i) |=> res_valid_q && $stable(res_q))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !cmd_ready_o) else $error("command taken while busy");
`endif

endmodule

// ===== hdl/distance_vector_route_table_lpm.sv =====
// Distance-vector route table with longest-prefix-match lookup. Commands
// enter a two-deep queue and are carried out one at a time by a sequencer
// that scans the table through a memory read port, one entry per cycle
// unless a broadcast is held by a busy output; a broadcast tick emits one
// result per entry. A new command starts only once the previous result
// has left, so output back-pressure delays the next command. Lookup picks
// the largest mask, then the smallest distance, then the lowest index.
// Results leave through a registered output that holds under back-pressure.
// The broadcast interval is written through its own channel; the user must
// write it only while the block is idle, which the block itself does not
// enforce. It resets to 1000000 ticks.
module distance_vector_route_table_lpm
  import dvrt_pkg::*;
#(
  parameter int unsigned ROUTE_SLOTS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0], address[33:2], route_mask[65:34], prefix_length[71:66],
  // hop_distance[87:72], port[91:88], zero fill
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_kind[1:0], hit[2], out_port[6:3], update_status[9:7],
  // adv_prefix[41:10], adv_mask[73:42], adv_distance[89:74], zero fill
  output logic [95:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  logic [23:0] interval_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) interval_q <= IntervalReset;
    else if (cfg_valid_i) interval_q <= cfg_data_i;
  end

  dvrt_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .opcode_i(s_axis_tdata[1:0]), .address_i(s_axis_tdata[33:2]),
    .route_mask_i(s_axis_tdata[65:34]), .prefix_length_i(s_axis_tdata[71:66]),
    .hop_distance_i(s_axis_tdata[87:72]), .port_i(s_axis_tdata[91:88]),
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  dvrt_back #(.ROUTE_SLOTS(ROUTE_SLOTS)) u_back (
    .clk_i, .rst_ni, .interval_i(interval_q),
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  // Pack result fields, lowest field first
  assign m_axis_tdata = {6'd0, res.adv_distance, res.adv_mask, res.adv_prefix,
                         res.status, res.out_port, res.hit, res.kind};
  assign m_axis_tlast = res.last;

endmodule
